>>> hw/rtl/sct_pkg.sv
// Shared types and constants for the cooperative task scheduler.
// Holds the command codes, the slot record layout and the sequencer states.
// No dependencies.
package sct_pkg;

    // Command codes carried on the input tuser field.
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_t;

    // Fixed field widths of the stream payloads.
    localparam int SLOT_W    = 3;
    localparam int TASK_W    = 8;
    localparam int TIME_W    = 16;
    localparam int PEND_W    = 8;

    // At most this many run results come out of one dispatch.
    localparam int MAX_OUT   = 8;
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    // Status codes of a result beat.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Value the sticky error takes once an add finds no free slot.
    localparam logic ERR_TOO_MANY_TASKS = 1'b1;

    // Saturation limit of the pending-run count.
    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // One slot record as kept in the slot memory.
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [PEND_W-1:0] pending;
    } entry_t;

    // Decisions the update unit reports back to the sequencer.
    typedef struct packed {
        logic pend_nz;
        logic one_shot;
    } alu_flags_t;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_FLUSH = 3'b100
    } state_t;

endpackage

>>> hw/rtl/cooperative_task_scheduler_unit.sv
// Top level of the cooperative task scheduler: command sequencer, slot valid
// bits, dispatch hold stage and output register. Depends on sct_pkg,
// sct_slot_ram and sct_slot_alu.
//
//  Channel   Dir  Signals                       Content
//  s_axis    in   tvalid tready tdata tuser     one command beat
//  m_axis    out  tvalid tready tdata tuser tlast  one result beat
//
// A command is taken only while the sequencer is idle. Delete acts on its
// target slot alone; add, tick and dispatch walk over the slot memory, one
// slot per cycle through its single read port and the shared update unit,
// unless a stalled result beat holds the walk.
// Reset clears the valid bits, the sticky error and all control state.
// A stalled result beat holds the walk at the slot that produces the next beat.
module cooperative_task_scheduler_unit
    import sct_pkg::*;
#(
    parameter int NUM_SLOTS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] task_id, [23:8] start_delay, [39:24] repeat_period,
    // [42:40] target_slot, [47:43] zero
    input  logic [47:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] slot, [10:3] run_task_id, [15:11] zero
    output logic [15:0] m_axis_tdata,
    // [0] status, [1] run, [2] error_sticky
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]   valid_reg, valid_next;
    logic                   full_reg, full_next;
    logic [OUT_CNT_W-1:0]   n_reg, n_next;

    // Latched command beat.
    cmd_t                   cmd_reg, cmd_next;
    logic [TASK_W-1:0]      tid_reg, tid_next;
    logic [TIME_W-1:0]      dly_reg, dly_next;
    logic [TIME_W-1:0]      per_reg, per_next;
    logic [SLOT_W-1:0]      tgt_reg, tgt_next;

    // Dispatch result held until it is known whether it is the last one.
    logic                   held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]      held_slot_reg, held_slot_next;
    logic [TASK_W-1:0]      held_tid_reg, held_tid_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic                   out_status_reg, out_status_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;
    logic [TASK_W-1:0]      out_tid_reg, out_tid_next;
    logic                   out_run_reg, out_run_next;
    logic                   out_err_reg, out_err_next;
    logic                   out_last_reg, out_last_next;

    // Memory and update unit connections.
    logic                   wr_en;
    entry_t                 wr_data;
    entry_t                 rd_data;
    entry_t                 cur;
    entry_t                 upd;
    alu_flags_t             flags;

    logic                   can_emit;
    logic                   last_slot;

    sct_slot_ram #(
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (idx_next),
        .rd_data (rd_data)
    );

    // A slot that is not valid reads as all zero.
    assign cur = valid_reg[idx_reg] ? rd_data : '0;

    sct_slot_alu u_alu (
        .cmd   (cmd_reg),
        .cur   (cur),
        .upd   (upd),
        .flags (flags)
    );

    assign can_emit  = !out_valid_reg || m_axis_tready;
    assign last_slot = (idx_reg == LAST_IDX);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_tid_reg, out_slot_reg};
    assign m_axis_tuser  = {out_err_reg, out_run_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        full_next       = full_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        tid_next        = tid_reg;
        dly_next        = dly_reg;
        per_next        = per_reg;
        tgt_next        = tgt_reg;
        held_valid_next = held_valid_reg;
        held_slot_next  = held_slot_reg;
        held_tid_next   = held_tid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_tid_next    = out_tid_reg;
        out_run_next    = out_run_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_data         = upd;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next        = cmd_t'(s_axis_tuser);
                    tid_next        = s_axis_tdata[7:0];
                    dly_next        = s_axis_tdata[23:8];
                    per_next        = s_axis_tdata[39:24];
                    tgt_next        = s_axis_tdata[42:40];
                    idx_next        = '0;
                    n_next          = '0;
                    held_valid_next = 1'b0;
                    state_next      = S_WALK;
                end
            end

            S_WALK:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (!valid_reg[idx_reg])
                        begin
                            // First free slot takes the new task.
                            if (can_emit)
                            begin
                                wr_en               = 1'b1;
                                wr_data.task_id     = tid_reg;
                                wr_data.delay       = dly_reg;
                                wr_data.period      = per_reg;
                                wr_data.pending     = '0;
                                valid_next[idx_reg] = 1'b1;
                                out_valid_next      = 1'b1;
                                out_status_next     = STATUS_OK;
                                out_slot_next       = SLOT_W'(idx_reg);
                                out_tid_next        = '0;
                                out_run_next        = 1'b0;
                                out_err_next        = full_reg;
                                out_last_next       = 1'b1;
                                state_next          = S_IDLE;
                            end
                        end
                        else if (last_slot)
                        begin
                            // Table full: set the sticky error.
                            if (can_emit)
                            begin
                                full_next       = ERR_TOO_MANY_TASKS;
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_FULL;
                                out_slot_next   = '0;
                                out_tid_next    = '0;
                                out_run_next    = 1'b0;
                                out_err_next    = ERR_TOO_MANY_TASKS;
                                out_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end

                    CMD_DELETE:
                    begin
                        // Out-of-range targets match no slot and change nothing.
                        if (can_emit)
                        begin
                            for (int s = 0; s < NUM_SLOTS; s++)
                            begin
                                if ({29'd0, tgt_reg} == 32'(s))
                                begin
                                    valid_next[s] = 1'b0;
                                end
                            end
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_OK;
                            out_slot_next   = tgt_reg;
                            out_tid_next    = '0;
                            out_run_next    = 1'b0;
                            out_err_next    = full_reg;
                            out_last_next   = 1'b1;
                            state_next      = S_IDLE;
                        end
                    end

                    CMD_TICK:
                    begin
                        // The last slot waits for room for the result beat.
                        if (!last_slot || can_emit)
                        begin
                            wr_en = valid_reg[idx_reg];
                            if (last_slot)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_OK;
                                out_slot_next   = '0;
                                out_tid_next    = '0;
                                out_run_next    = 1'b0;
                                out_err_next    = full_reg;
                                out_last_next   = 1'b1;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                idx_next = idx_reg + IDX_W'(1);
                            end
                        end
                    end

                    default:
                    begin
                        // Dispatch: each pending slot yields one run beat, up to MAX_OUT beats.
                        if (n_reg == OUT_CNT_W'(MAX_OUT))
                        begin
                            state_next = S_FLUSH;
                        end
                        else if (flags.pend_nz)
                        begin
                            if (!held_valid_reg || can_emit)
                            begin
                                if (held_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = STATUS_OK;
                                    out_slot_next   = held_slot_reg;
                                    out_tid_next    = held_tid_reg;
                                    out_run_next    = 1'b1;
                                    out_err_next    = full_reg;
                                    out_last_next   = 1'b0;
                                end
                                held_valid_next = 1'b1;
                                held_slot_next  = SLOT_W'(idx_reg);
                                held_tid_next   = cur.task_id;
                                n_next          = n_reg + OUT_CNT_W'(1);
                                if (flags.one_shot)
                                begin
                                    valid_next[idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    wr_en = 1'b1;
                                end
                                if (last_slot)
                                begin
                                    state_next = S_FLUSH;
                                end
                                else
                                begin
                                    idx_next = idx_reg + IDX_W'(1);
                                end
                            end
                        end
                        else if (last_slot)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                endcase
            end

            S_FLUSH:
            begin
                // Close the dispatch with the held beat, or an empty one.
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_OK;
                    out_err_next    = full_reg;
                    out_last_next   = 1'b1;
                    if (held_valid_reg)
                    begin
                        out_slot_next = held_slot_reg;
                        out_tid_next  = held_tid_reg;
                        out_run_next  = 1'b1;
                    end
                    else
                    begin
                        out_slot_next = '0;
                        out_tid_next  = '0;
                        out_run_next  = 1'b0;
                    end
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            valid_reg      <= '0;
            full_reg       <= 1'b0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            valid_reg      <= valid_next;
            full_reg       <= full_next;
            n_reg          <= n_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        tid_reg        <= tid_next;
        dly_reg        <= dly_next;
        per_reg        <= per_next;
        tgt_reg        <= tgt_next;
        held_slot_reg  <= held_slot_next;
        held_tid_reg   <= held_tid_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_tid_reg    <= out_tid_next;
        out_run_reg    <= out_run_next;
        out_err_reg    <= out_err_next;
        out_last_reg   <= out_last_next;
    end

endmodule

>>> hw/rtl/sct_slot_ram.sv
// Slot record memory: one write port and one read port with registered data.
// Depends on sct_pkg for the record type.
module sct_slot_ram
    import sct_pkg::*;
#(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> hw/rtl/sct_slot_alu.sv
// Shared slot update unit: computes the new record of one slot for a tick
// or a dispatch, and the decisions the sequencer needs. Depends on sct_pkg.
module sct_slot_alu
    import sct_pkg::*;
(
    input  cmd_t       cmd,
    input  entry_t     cur,
    output entry_t     upd,
    output alu_flags_t flags
);

    logic delay_zero;

    assign delay_zero     = (cur.delay == '0);
    assign flags.pend_nz  = (cur.pending != '0);
    assign flags.one_shot = (cur.period == '0);

    always_comb
    begin
        upd = cur;
        case (cmd)
            CMD_TICK:
            begin
                // A due slot gains a run and reloads from a nonzero period.
                if (delay_zero)
                begin
                    if (cur.pending != PEND_MAX)
                    begin
                        upd.pending = cur.pending + PEND_W'(1);
                    end
                    if (!flags.one_shot)
                    begin
                        upd.delay = cur.period;
                    end
                end
                else
                begin
                    upd.delay = cur.delay - TIME_W'(1);
                end
            end
            CMD_DISPATCH:
            begin
                upd.pending = cur.pending - PEND_W'(1);
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

endmodule
